// File: hdl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the integer to radix string converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Radix limits and fixed characters
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] DIGIT_MAX  = 6'd35;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] TERM_CHAR  = 8'h00;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] ALPHA_CHAR = 8'h61;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT,
        ST_TERM
    } t_state;

    // Map a digit magnitude to its ASCII character, clamping above 35
    function automatic logic [7:0] digit_char(input logic [5:0] digit);
        logic [5:0] d;
        d = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
        if (d < 6'd10) begin
            digit_char = ZERO_CHAR + {2'b00, d};
        end else begin
            digit_char = ALPHA_CHAR + {2'b00, d - 6'd10};
        end
    endfunction

endpackage

// File: hdl/integer_to_radix_string.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_string
// Converts a signed integer to its ASCII text in a base from 2 to 36.
// ----------------------------------------------------------------------------
// One input transfer carries a signed value and a base. The block answers with
// the text of the value, most significant character first: a '-' for a
// negative value, the digits 0-9 and a-z, then a zero byte marked with tlast.
// A base outside 2..36 gives only the zero byte. The magnitude is divided by
// the base in a bit-serial restoring divider, one quotient bit per cycle, and
// each full pass over the value yields one digit; digits are pushed on a
// shift-register stack and then popped out one character per cycle while the
// sink is ready. One conversion is in flight at a time; the next input is
// taken once the last character is in the output register.
// ----------------------------------------------------------------------------
module integer_to_radix_string #(
    parameter int VALUE_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side, tdata fields from bit 0: value, base, zero fill
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [((VALUE_BITS+13)/8)*8-1:0] i_s_tdata,
    // master side, tdata fields from bit 0: character
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tlast
);
    import itoa_pkg::*;

    localparam int CNT_W   = $clog2(VALUE_BITS);
    localparam int DEPTH_W = $clog2(VALUE_BITS + 1);

    // State and datapath registers
    t_state                 r_state, n_state;
    logic [VALUE_BITS-1:0]  r_quo, n_quo;
    logic [5:0]             r_rem, n_rem;
    logic [5:0]             r_base, n_base;
    logic                   r_neg, n_neg;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [DEPTH_W-1:0]     r_depth, n_depth;
    logic [5:0]             r_stack [VALUE_BITS];
    logic                   r_ovalid, n_ovalid;
    logic [7:0]             r_char, n_char;
    logic                   r_last, n_last;

    // Combinational helpers
    logic                   w_in_xfer;
    logic                   w_load;
    logic                   w_push;
    logic                   w_pop;
    logic [VALUE_BITS-1:0]  w_in_value;
    logic [5:0]             w_in_base;
    logic                   w_base_ok;
    logic [6:0]             w_trial;
    logic                   w_ge;
    logic [5:0]             w_rem_next;
    logic [VALUE_BITS-1:0]  w_quo_next;
    logic                   w_last_bit;

    assign w_in_value = i_s_tdata[VALUE_BITS-1:0];
    assign w_in_base  = i_s_tdata[VALUE_BITS+5:VALUE_BITS];
    assign w_base_ok  = (w_in_base >= BASE_MIN) && (w_in_base <= BASE_MAX);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_load     = !r_ovalid || i_m_tready;

    // One restoring division step
    assign w_trial    = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge       = w_trial >= {1'b0, r_base};
    assign w_rem_next = w_ge ? 6'(w_trial - {1'b0, r_base}) : w_trial[5:0];
    assign w_quo_next = {r_quo[VALUE_BITS-2:0], w_ge};
    assign w_last_bit = (r_cnt == CNT_W'(VALUE_BITS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_base_ok ? ST_DIVIDE : ST_TERM;
                end
            end
            ST_DIVIDE: begin
                if (w_last_bit && (w_quo_next == '0)) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_load) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_load && (r_depth == DEPTH_W'(1))) begin
                    n_state = ST_TERM;
                end
            end
            ST_TERM: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        o_s_tready = 1'b0;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_base     = r_base;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_depth    = r_depth;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_char     = r_char;
        n_last     = r_last;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (w_in_xfer) begin
                    n_neg   = w_in_value[VALUE_BITS-1];
                    n_quo   = w_in_value[VALUE_BITS-1] ? (~w_in_value + 1'b1) : w_in_value;
                    n_rem   = '0;
                    n_base  = w_in_base;
                    n_cnt   = '0;
                    n_depth = '0;
                end
            end
            ST_DIVIDE: begin
                n_quo = w_quo_next;
                n_rem = w_rem_next;
                n_cnt = r_cnt + 1'b1;
                if (w_last_bit) begin
                    w_push  = 1'b1;
                    n_depth = r_depth + 1'b1;
                    n_rem   = '0;
                    n_cnt   = '0;
                end
            end
            ST_SIGN: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_char   = MINUS_CHAR;
                    n_last   = 1'b0;
                end
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_char   = digit_char(r_stack[0]);
                    n_last   = 1'b0;
                    w_pop    = 1'b1;
                    n_depth  = r_depth - 1'b1;
                end
            end
            ST_TERM: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    n_char   = TERM_CHAR;
                    n_last   = 1'b1;
                end
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_depth  <= '0;
            r_neg    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_depth  <= n_depth;
            r_neg    <= n_neg;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_base <= n_base;
        r_char <= n_char;
        r_last <= n_last;
    end

    // Digit stack: push the new digit at the top, pop shifts toward the top
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[0] <= w_rem_next;
            for (int i = 1; i < VALUE_BITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (w_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

`ifndef SYNTHESIS
    // Partial remainder stays below the base while dividing
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVIDE) |-> (r_rem < r_base))
        else $error("remainder not below base");

    // Stack never holds more digits than the value has bits
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(VALUE_BITS))
        else $error("digit stack overflow");

    // Emitting digits requires a non-empty stack
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_depth != '0))
        else $error("emit with empty digit stack");

    // The marked last character is always the zero terminator
    a_last_is_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == TERM_CHAR))
        else $error("last character is not the terminator");

    // An accepted input closes the input side on the next cycle
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_s_tready)
        else $error("input taken while a conversion is running");
`endif

endmodule
